[rtl/min_tracking_stack_macros.svh]
// Assertion macros for the min tracking stack.
// Included by the modules that carry checks; needs i_clk and i_rst_n in scope.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

`ifndef SYNTHESIS
`define MTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("min_tracking_stack check failed");
`define MTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("min_tracking_stack check failed");
`else
`define MTS_ASSERT_IMP(lbl, ante, cons)
`define MTS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/mts_pkg.sv]
// Shared types and action codes for the min tracking stack.
// No dependencies.
package mts_pkg;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    localparam int unsigned CNT_W = 11;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        logic               error;
        logic [CNT_W-1:0]   count;
    } t_out_resp;

endpackage

[rtl/mts_ram.sv]
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
module mts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/min_tracking_stack.sv]
// Min tracking stack top level: LIFO of signed words reporting the running minimum.
// Depends on mts_pkg, mts_ram and min_tracking_stack_macros.svh.
//
//  channel | dir | handshake                  | payload
//  in      | in  | i_in_valid / o_in_ready    | i_in  (action, value)
//  out     | out | o_out_valid / i_out_ready  | o_out (top, min, empty, error, count)
//
// Push, peek, failed pop and a pop down to empty are answered from the registers alone.
// A pop that leaves entries holds off new requests in S_POP while the new top comes from the RAM read.
// The top entry lives in registers; entries below it live in the RAM as {value, min}.
// Synchronous active-low reset clears the count; no RAM clearing pass is needed.
// A request is taken in S_RUN while the result register is empty or being drained.
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mts_pkg::t_in_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mts_pkg::t_out_resp o_out
);
    import mts_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {S_RUN, S_POP} t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_top_val, n_top_val;
    logic signed [31:0] r_top_min, n_top_min;
    t_out_resp          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [63:0]        ram_wdata, ram_rdata;

    logic               in_acc;
    logic               load_out;
    logic               out_err;
    logic [CW-1:0]      cnt_m1, cnt_m2;
    logic [CW+CNT_W-1:0] cnt_wide;

    mts_ram #(
        .WIDTH (64),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_RUN) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign cnt_m1    = r_count - CW'(1);
    assign cnt_m2    = r_count - CW'(2);
    assign ram_waddr = cnt_m1[AW-1:0];
    assign ram_raddr = cnt_m2[AW-1:0];
    assign ram_wdata = {r_top_val, r_top_min};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top_val   = r_top_val;
        n_top_min   = r_top_min;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load_out    = 1'b0;
        out_err     = 1'b0;
        cnt_wide    = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_RUN: begin
                if (in_acc) begin
                    load_out = 1'b1;
                    case (i_in.action)
                        ACT_PUSH: begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                out_err = 1'b1;
                            end else begin
                                // current top moves down into the RAM
                                ram_we    = (r_count != '0);
                                n_top_val = i_in.value;
                                n_top_min = ((r_count != '0) && (r_top_min < i_in.value)) ?
                                            r_top_min : i_in.value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                out_err = 1'b1;
                            end else if (r_count == CW'(1)) begin
                                n_count = '0;
                            end else begin
                                // new top arrives from RAM next cycle
                                ram_re   = 1'b1;
                                n_count  = cnt_m1;
                                n_state  = S_POP;
                                load_out = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_top_val = ram_rdata[63:32];
                n_top_min = ram_rdata[31:0];
                n_state   = S_RUN;
                load_out  = 1'b1;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        if (load_out) begin
            cnt_wide      = {{CNT_W{1'b0}}, n_count};
            n_out_valid   = 1'b1;
            n_out.error   = out_err;
            n_out.count   = cnt_wide[CNT_W-1:0];
            if (n_count == '0) begin
                n_out.top_value = '0;
                n_out.min_value = '0;
                n_out.is_empty  = 1'b1;
            end else begin
                n_out.top_value = n_top_val;
                n_out.min_value = n_top_min;
                n_out.is_empty  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_top_val <= n_top_val;
        r_top_min <= n_top_min;
        r_out     <= n_out;
    end

    `MTS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(STACK_DEPTH))
    `MTS_ASSERT_IMP(a_top_min_order, r_count != '0, r_top_min <= r_top_val)
    `MTS_ASSERT_NXT(a_pop_wait, in_acc && (i_in.action == ACT_POP) && (r_count > CW'(1)),
        (r_state == S_POP) && !o_out_valid && !o_in_ready)
    `MTS_ASSERT_IMP(a_empty_zero, o_out_valid && o_out.is_empty,
        (o_out.top_value == '0) && (o_out.min_value == '0) && (o_out.count == '0))

endmodule

[tb/min_tracking_stack_test.sv]
// Self-checking testbench for min_tracking_stack: directed table, random push/pop/peek traffic,
// a push-heavy burst under output back-pressure, then a drain to empty and pops past empty.
// Depends on mts_pkg and the min_tracking_stack RTL.
`timescale 1ns / 100ps

module min_tracking_stack_test;

    import mts_pkg::*;

    localparam int STACK_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 450;
    localparam int BURST_ITEMS  = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;

    // Unused action code, behaves as a peek
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        t_in_req   req;
        bit        typed;
        t_out_resp want;
    } t_step_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_req   i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_resp o_out;

    // Shadow copy of the stack contents
    logic signed [31:0] shadow_val [STACK_DEPTH];
    logic signed [31:0] shadow_min [STACK_DEPTH];
    int                 shadow_depth;

    t_out_resp pending_resp [$];
    t_step_row dir_rows [$];
    int        mismatches;
    bit        gaps_on;
    bit        hold_flag;

    min_tracking_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: %s got %h want %h", $time, field, got, want);
    endtask

    // Applies one request to the shadow stack and gives the result it should produce
    task automatic stack_apply(input t_in_req req, output t_out_resp resp);
        resp = '0;
        case (req.action)
            ACT_PUSH: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    resp.error = 1'b1;
                end else begin
                    shadow_val[shadow_depth] = req.value;
                    if (shadow_depth > 0 && shadow_min[shadow_depth-1] < req.value)
                        shadow_min[shadow_depth] = shadow_min[shadow_depth-1];
                    else
                        shadow_min[shadow_depth] = req.value;
                    shadow_depth++;
                end
            end
            ACT_POP: begin
                if (shadow_depth == 0)
                    resp.error = 1'b1;
                else
                    shadow_depth--;
            end
            default: ;
        endcase
        resp.count = CNT_W'(shadow_depth);
        if (shadow_depth == 0) begin
            resp.is_empty = 1'b1;
        end else begin
            resp.top_value = shadow_val[shadow_depth-1];
            resp.min_value = shadow_min[shadow_depth-1];
        end
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            4, 5:    return $signed(32'($urandom_range(16))) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_req rand_req(input int push_pct, input int pop_pct);
        t_in_req req;
        int      r;
        r = $urandom_range(99);
        if (r < push_pct)
            req.action = ACT_PUSH;
        else if (r < push_pct + pop_pct)
            req.action = ACT_POP;
        else if (r < 96)
            req.action = ACT_PEEK;
        else
            req.action = ACT_SPARE;
        req.value = rand_value();
        return req;
    endfunction

    task automatic add_row(input logic [1:0] act, input logic signed [31:0] v, input bit typed,
                           input logic signed [31:0] top, input logic signed [31:0] mn,
                           input bit empty, input bit err, input int cnt);
        t_step_row row;
        row.req.action      = act;
        row.req.value       = v;
        row.typed           = typed;
        row.want.top_value  = top;
        row.want.min_value  = mn;
        row.want.is_empty   = empty;
        row.want.error      = err;
        row.want.count      = CNT_W'(cnt);
        dir_rows.push_back(row);
    endtask

    // Holds valid and payload until the request is taken, then logs what should come back
    task automatic offer(input t_in_req req, input bit typed, input t_out_resp typed_resp);
        t_out_resp pred;
        while (gaps_on && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        stack_apply(req, pred);
        pending_resp.push_back(typed ? typed_resp : pred);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Receiver: random back-pressure, plus one long hold when asked
    initial begin
        forever begin
            if (hold_flag) begin
                hold_flag = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= !gaps_on || $urandom_range(99) >= 28;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected result", o_out.top_value, '0);
            end else begin
                want = pending_resp.pop_front();
                if (o_out.top_value !== want.top_value)
                    report_mismatch("top_value", o_out.top_value, want.top_value);
                if (o_out.min_value !== want.min_value)
                    report_mismatch("min_value", o_out.min_value, want.min_value);
                if (o_out.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(o_out.is_empty), 32'(want.is_empty));
                if (o_out.error !== want.error)
                    report_mismatch("error", 32'(o_out.error), 32'(want.error));
                if (o_out.count !== want.count)
                    report_mismatch("count", 32'(o_out.count), 32'(want.count));
            end
        end
    end

    initial begin
        mismatches   = 0;
        shadow_depth = 0;
        gaps_on      = 1'b1;
        hold_flag    = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;

        //      action     value         chk top      min      emp err cnt
        add_row(ACT_PEEK,  0,            1,  0,       0,       1,  0,  0);
        add_row(ACT_POP,   0,            1,  0,       0,       1,  1,  0);
        add_row(ACT_SPARE, 0,            1,  0,       0,       1,  0,  0);
        add_row(ACT_PUSH,  VAL_MAX,      1,  VAL_MAX, VAL_MAX, 0,  0,  1);
        add_row(ACT_PUSH,  VAL_MIN,      1,  VAL_MIN, VAL_MIN, 0,  0,  2);
        add_row(ACT_PUSH,  0,            1,  0,       VAL_MIN, 0,  0,  3);
        add_row(ACT_PEEK,  0,            1,  0,       VAL_MIN, 0,  0,  3);
        add_row(ACT_POP,   0,            1,  VAL_MIN, VAL_MIN, 0,  0,  2);
        add_row(ACT_POP,   0,            1,  VAL_MAX, VAL_MAX, 0,  0,  1);
        add_row(ACT_POP,   0,            1,  0,       0,       1,  0,  0);
        add_row(ACT_POP,   0,            1,  0,       0,       1,  1,  0);
        add_row(ACT_PUSH,  -1,           1,  -1,      -1,      0,  0,  1);
        add_row(ACT_PUSH,  -1,           1,  -1,      -1,      0,  0,  2);
        add_row(ACT_PUSH,  5,            1,  5,       -1,      0,  0,  3);
        add_row(ACT_POP,   32'hdeadbeef, 1,  -1,      -1,      0,  0,  2);
        add_row(ACT_PEEK,  12345,        1,  -1,      -1,      0,  0,  2);
        add_row(ACT_PUSH,  -2,           1,  -2,      -2,      0,  0,  3);
        add_row(ACT_POP,   0,            1,  -1,      -1,      0,  0,  2);
        add_row(ACT_POP,   0,            1,  -1,      -1,      0,  0,  1);
        add_row(ACT_POP,   0,            1,  0,       0,       1,  0,  0);
        add_row(ACT_PUSH,  100,          0,  0,       0,       0,  0,  0);
        add_row(ACT_PUSH,  50,           0,  0,       0,       0,  0,  0);
        add_row(ACT_PUSH,  75,           0,  0,       0,       0,  0,  0);
        add_row(ACT_SPARE, -7,           0,  0,       0,       0,  0,  0);
        add_row(ACT_POP,   0,            0,  0,       0,       0,  0,  0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < dir_rows.size(); i++)
            offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        settle();

        // Mixed traffic, with a stretch of no gaps on either side
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = !(n >= 150 && n < 300);
            offer(rand_req(45, 35), 1'b0, '0);
        end
        gaps_on = 1'b1;

        // Sender waits for the output side to empty before the burst
        settle();

        // Push-heavy burst; the receiver holds off at its start so the input stalls
        hold_flag = 1'b1;
        for (int n = 0; n < BURST_ITEMS; n++)
            offer(rand_req(90, 0), 1'b0, '0);

        // Drain back down, then pop past empty
        while (shadow_depth > 0)
            offer(rand_req(10, 80), 1'b0, '0);
        repeat (3) offer('{action: ACT_POP, value: rand_value()}, 1'b0, '0);

        i_in_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
